// File: src/lru_frame_replacer_defines.svh
// ----------------------------------------------------------------------------
// lru frame replacer assertion macros
// concurrent checks clocked on clk_i, muted while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_DEFINES_SVH
`define LRU_FRAME_REPLACER_DEFINES_SVH

// property that must hold at every edge
`define LFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by a result in the next cycle
`define LFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: src/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the lru frame replacer
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

  localparam int unsigned DEF_FRAMES = 64;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_VICTIM = 2'd0,
    KIND_PIN    = 2'd1,
    KIND_UNPIN  = 2'd2
  } kind_e;

  // result of one operation
  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
  } res_t;

  // memory port strobes
  typedef struct packed {
    logic rd_en;
    logic newer_we;
    logic older_we;
  } mem_cmd_t;

endpackage

`default_nettype wire

// File: src/lfr_link_mem.sv
// ----------------------------------------------------------------------------
// lfr_link_mem
// link storage: newer links, and older links with the membership bit on top
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_link_mem #(
  parameter int unsigned FRAMES = lfr_pkg::DEF_FRAMES
) (
  input  wire                          clk_i,
  input  wire lfr_pkg::mem_cmd_t       cmd_i,
  input  wire [$clog2(FRAMES)-1:0]     rd_addr_i,
  input  wire [$clog2(FRAMES)-1:0]     newer_waddr_i,
  input  wire [$clog2(FRAMES)-1:0]     newer_wdata_i,
  input  wire [$clog2(FRAMES)-1:0]     older_waddr_i,
  input  wire [$clog2(FRAMES):0]       older_wdata_i,
  output logic [$clog2(FRAMES)-1:0]    newer_rdata_o,
  output logic [$clog2(FRAMES):0]      older_rdata_o
);
  import lfr_pkg::*;

  localparam int unsigned IW = $clog2(FRAMES);

  logic [IW-1:0] newer_mem [FRAMES];
  logic [IW:0]   older_mem [FRAMES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.newer_we) begin
      newer_mem[newer_waddr_i] <= newer_wdata_i;
    end
    if (cmd_i.rd_en) begin
      newer_rdata_o <= newer_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.older_we) begin
      older_mem[older_waddr_i] <= older_wdata_i;
    end
    if (cmd_i.rd_en) begin
      older_rdata_o <= older_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/lfr_ctrl.sv
// ----------------------------------------------------------------------------
// lfr_ctrl
// operation sequencer: read node, relink neighbours, finish node, report
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_frame_replacer_defines.svh"

module lfr_ctrl #(
  parameter int unsigned FRAMES = lfr_pkg::DEF_FRAMES
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [lfr_pkg::KIND_W-1:0]    in_kind_i,
  input  wire [lfr_pkg::FRAME_W-1:0]   in_frame_i,
  output logic                         res_valid_o,
  input  wire                          res_ready_i,
  output lfr_pkg::res_t                res_o,
  output lfr_pkg::mem_cmd_t            mem_cmd_o,
  output logic [$clog2(FRAMES)-1:0]    rd_addr_o,
  output logic [$clog2(FRAMES)-1:0]    newer_waddr_o,
  output logic [$clog2(FRAMES)-1:0]    newer_wdata_o,
  output logic [$clog2(FRAMES)-1:0]    older_waddr_o,
  output logic [$clog2(FRAMES):0]      older_wdata_o,
  input  wire [$clog2(FRAMES)-1:0]     newer_rdata_i,
  input  wire [$clog2(FRAMES):0]       older_rdata_i
);
  import lfr_pkg::*;

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_UNLINK = 2'd1;
  localparam logic [1:0] ACT_INSERT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [1:0]        act_q, act_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [IW-1:0]     fidx_q, fidx_d;
  logic              inrange_q, inrange_d;
  logic [IW-1:0]     newest_q, newest_d;
  logic [IW-1:0]     oldest_q, oldest_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     clr_q, clr_d;
  logic              found_q, found_d;
  logic [IW-1:0]     vframe_q, vframe_d;

  logic              accept;
  logic              member;
  logic [IW-1:0]     link_o;
  logic [IW-1:0]     link_n;
  logic              do_unlink;
  logic              do_insert;

  assign accept = in_valid_i && in_ready_o;
  assign member = older_rdata_i[IW];
  assign link_o = older_rdata_i[IW-1:0];
  assign link_n = newer_rdata_i;

  always_comb begin
    do_unlink = 1'b0;
    do_insert = 1'b0;
    case (kind_q)
      KIND_VICTIM: do_unlink = (count_q != '0);
      KIND_PIN:    do_unlink = inrange_q && member;
      KIND_UNPIN:  do_insert = inrange_q && !member;
      default: begin
        do_unlink = 1'b0;
        do_insert = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    act_d         = act_q;
    kind_d        = kind_q;
    fidx_d        = fidx_q;
    inrange_d     = inrange_q;
    newest_d      = newest_q;
    oldest_d      = oldest_q;
    count_d       = count_q;
    clr_d         = clr_q;
    found_d       = found_q;
    vframe_d      = vframe_q;
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    mem_cmd_o     = '0;
    rd_addr_o     = oldest_q;
    newer_waddr_o = fidx_q;
    newer_wdata_o = fidx_q;
    older_waddr_o = fidx_q;
    older_wdata_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        // sweep membership bits to zero
        mem_cmd_o.older_we = 1'b1;
        older_waddr_o      = clr_q;
        older_wdata_o      = '0;
        clr_d              = clr_q + IW'(1);
        if (clr_q == IW'(FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = (in_kind_i == KIND_VICTIM) ? oldest_q : IW'(in_frame_i);
        if (accept) begin
          mem_cmd_o.rd_en = 1'b1;
          kind_d          = in_kind_i;
          fidx_d          = rd_addr_o;
          inrange_d       = (32'(in_frame_i) < FRAMES);
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        act_d    = ACT_NONE;
        found_d  = 1'b0;
        vframe_d = '0;
        if (do_unlink) begin
          act_d = ACT_UNLINK;
          if (kind_q == KIND_VICTIM) begin
            found_d  = 1'b1;
            vframe_d = fidx_q;
          end
          if (fidx_q == oldest_q) begin
            oldest_d = link_n;
          end else begin
            mem_cmd_o.newer_we = 1'b1;
            newer_waddr_o      = link_o;
            newer_wdata_o      = link_n;
          end
          if (fidx_q == newest_q) begin
            newest_d = link_o;
          end else begin
            mem_cmd_o.older_we = 1'b1;
            older_waddr_o      = link_n;
            older_wdata_o      = {1'b1, link_o};
          end
          count_d = count_q - CW'(1);
          if (count_q == CW'(1)) begin
            newest_d = '0;
            oldest_d = '0;
          end
        end else if (do_insert) begin
          act_d              = ACT_INSERT;
          mem_cmd_o.older_we = 1'b1;
          older_waddr_o      = fidx_q;
          newest_d           = fidx_q;
          count_d            = count_q + CW'(1);
          if (count_q == '0) begin
            oldest_d      = fidx_q;
            older_wdata_o = {1'b1, fidx_q};
          end else begin
            older_wdata_o      = {1'b1, newest_q};
            mem_cmd_o.newer_we = 1'b1;
            newer_waddr_o      = newest_q;
            newer_wdata_o      = fidx_q;
          end
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        // second write to the node itself; repeating it while stalled is harmless
        case (act_q)
          ACT_UNLINK: begin
            mem_cmd_o.older_we = 1'b1;
            older_wdata_o      = '0;
          end
          ACT_INSERT: begin
            mem_cmd_o.newer_we = 1'b1;
            newer_wdata_o      = fidx_q;
          end
          default: begin
            mem_cmd_o = '0;
          end
        endcase
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.found = found_q;
  assign res_o.frame = FRAME_W'(vframe_q);
  assign res_o.count = COUNT_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      act_q    <= ACT_NONE;
      newest_q <= '0;
      oldest_q <= '0;
      count_q  <= '0;
      clr_q    <= '0;
      found_q  <= 1'b0;
      vframe_q <= '0;
    end else begin
      state_q  <= state_d;
      act_q    <= act_d;
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      clr_q    <= clr_d;
      found_q  <= found_d;
      vframe_q <= vframe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    fidx_q    <= fidx_d;
    inrange_q <= inrange_d;
  end

  `LFR_ASSERT(a_count_max, count_q <= CW'(FRAMES), "evictable count exceeds frame count")
  `LFR_ASSERT(a_empty_ends, (count_q != '0) || (newest_q == '0 && oldest_q == '0), "empty list with stale ends")
  `LFR_ASSERT(a_count_in_exec, (count_q == $past(count_q)) || ($past(state_q) == S_EXEC), "count moved outside exec")
  `LFR_ASSERT_NEXT(a_accept_exec, in_valid_i && in_ready_o, state_q == S_EXEC, "accepted beat not executed")

endmodule

`default_nettype wire

// File: src/lru_frame_replacer.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer
// evictable frame list kept as a doubly linked list in link memories
// ----------------------------------------------------------------------------
// sequence: node read on an accepted input beat, neighbour relink, node write
//   with the result, then the result is registered for m_axis
// s_axis_tready is high only when idle, so a new beat is taken only after the
//   last one has finished these steps (each link memory has a single write port);
//   a result held up by m_axis_tready keeps the sequencer in its last step
// reset: control clears at once, then a sweep over every frame zeroes the
//   membership bits; s_axis_tready stays low for that sweep
// a finished result waits in the output register while the next beat is taken
`default_nettype none

module lru_frame_replacer #(
  parameter int unsigned FRAMES = lfr_pkg::DEF_FRAMES
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [lfr_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [5:0] frame_index, [7:6] zero
  input  wire [lfr_pkg::KIND_W-1:0]         s_axis_tuser,   // [1:0] kind
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [lfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [5:0] victim_frame,
                                                            // [12:6] evictable_count,
                                                            // [15:13] zero
  output logic                              m_axis_tuser    // [0] victim_found
);
  import lfr_pkg::*;

  localparam int unsigned IW = $clog2(FRAMES);

  mem_cmd_t      mem_cmd;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] newer_waddr;
  logic [IW-1:0] newer_wdata;
  logic [IW-1:0] older_waddr;
  logic [IW:0]   older_wdata;
  logic [IW-1:0] newer_rdata;
  logic [IW:0]   older_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;

  // output register
  logic m_valid_q, m_valid_d;
  res_t m_res_q, m_res_d;

  // link memories: newer link per frame, older link plus membership bit
  lfr_link_mem #(
    .FRAMES (FRAMES)
  ) u_mem (
    .clk_i         (clk_i),
    .cmd_i         (mem_cmd),
    .rd_addr_i     (rd_addr),
    .newer_waddr_i (newer_waddr),
    .newer_wdata_i (newer_wdata),
    .older_waddr_i (older_waddr),
    .older_wdata_i (older_wdata),
    .newer_rdata_o (newer_rdata),
    .older_rdata_o (older_rdata)
  );

  // sequencer holding list ends, count and the clearing sweep
  lfr_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_kind_i     (s_axis_tuser),
    .in_frame_i    (s_axis_tdata[FRAME_W-1:0]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_cmd_o     (mem_cmd),
    .rd_addr_o     (rd_addr),
    .newer_waddr_o (newer_waddr),
    .newer_wdata_o (newer_wdata),
    .older_waddr_o (older_waddr),
    .older_wdata_o (older_wdata),
    .newer_rdata_i (newer_rdata),
    .older_rdata_i (older_rdata)
  );

  // slot is free when empty or being drained this cycle
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_res_d   = res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_res_q.found;
  assign m_axis_tdata  = {(OUT_DATA_W - FRAME_W - COUNT_W)'(0), m_res_q.count, m_res_q.frame};

endmodule

`default_nettype wire
